// ===== design/sti_pkg.sv =====
// Package for the smoothed trapezoid integrator.
// Holds the default window length and the stream payload widths.
// No dependencies.
`default_nettype none

package sti_pkg;

  // default moving-average window length, in samples
  localparam int WINDOW_DEF = 5;

  // input request: sample_time [31:0], sample_value [47:32]
  localparam int TIME_W      = 32;
  localparam int VALUE_W     = 16;
  localparam int IN_TDATA_W  = 48;

  // result request: running_integral [63:0], area_increment [111:64], rising [112]
  localparam int ACC_W       = 64;
  localparam int INC_W       = 48;
  localparam int OUT_TDATA_W = 120;

  // low part of the product that the two-step divide keeps aside
  localparam int SPLIT_LO    = 26;

endpackage

`default_nettype wire

// ===== design/smoothed_trapezoid_integrator.sv =====
// Top level of the smoothed trapezoid integrator: window history, running
// sum, magnitude multiply, two-step constant divide and saturating accumulator.
// Depends on sti_pkg.
//
// Usage
//   Input stream (in_*): one sample per request, time stamp in ticks and a
//   signed 16-bit value. Result stream (out_*): running integral, this step's
//   trapezoid area and a rising flag.
//   The first WINDOW samples fill the history and give no result; each later
//   sample gives exactly one result.
//   Pipeline: an accepted sample passes the window/sum stage, the multiply stage,
//   two multiply-and-correct stages per divide half, then the accumulator/output
//   register, which presents its result.
//   Throughput: one sample per cycle. Every stage carries a valid bit and
//   loads whenever it is empty or its successor moves, so a stalled receiver
//   only halts the stages that hold results; bubbles ahead of it keep filling
//   and in_tready stays high until the pipeline is full.
//   Reset (rst_n low, synchronous) clears the history, the window sum, the
//   warm-up count, the accumulator and all valid bits.
//   When out_tready is low the result request holds unchanged.
`default_nettype none

module smoothed_trapezoid_integrator #(
  parameter int WINDOW = sti_pkg::WINDOW_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // sample_time [31:0], sample_value [47:32]
  input  wire logic [sti_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // running_integral [63:0], area_increment [111:64], rising [112], zero fill
  output logic [sti_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  import sti_pkg::*;

  localparam int DIV    = 2 * WINDOW;
  localparam int RW     = $clog2(DIV);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = VALUE_W + $clog2(WINDOW);
  localparam int S_W    = SUM_W + 1;
  localparam int DX_W   = TIME_W + 1;
  localparam int PROD_W = TIME_W + S_W;
  localparam int LO     = SPLIT_LO;
  localparam int HW     = PROD_W - LO;
  localparam int XW     = LO + RW;
  // reciprocals of DIV, scaled to the numerator width of each divide half
  localparam logic [HW-1:0] RH = HW'((64'd1 << HW) / DIV);
  localparam logic [XW-1:0] RX = XW'((64'd1 << XW) / DIV);

  // ---------------------------------------------------------------- control
  logic in_fire, warm;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, ov_r;
  logic en1, en2, en3, en4, en5, en6, en_out;

  assign en_out    = !ov_r || out_tready;
  assign en6       = !v6_r || en_out;
  assign en5       = !v5_r || en6;
  assign en4       = !v4_r || en5;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign in_fire   = in_tvalid && in_tready;

  // ---------------------------------------------------------------- window state
  logic signed [VALUE_W-1:0] vhist_r [WINDOW];
  logic        [TIME_W-1:0]  thist_r [WINDOW];
  logic signed [SUM_W-1:0]   psum_r;
  logic        [CNT_W-1:0]   seen_r;
  logic signed [VALUE_W-1:0] in_value;
  logic        [TIME_W-1:0]  in_time;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [S_W-1:0]     s_nxt;
  logic signed [DX_W-1:0]    dx_nxt;

  assign in_time  = in_tdata[TIME_W-1:0];
  assign in_value = in_tdata[TIME_W+VALUE_W-1:TIME_W];
  assign warm     = (seen_r == CNT_W'(WINDOW));

  // slide the window sum; the oldest slot is still zero during warm-up
  assign sum_nxt = psum_r - SUM_W'(vhist_r[0]) + SUM_W'(in_value);
  assign s_nxt   = S_W'(psum_r) + S_W'(sum_nxt);
  assign dx_nxt  = $signed({1'b0, thist_r[1]}) - $signed({1'b0, thist_r[0]});

  // shift the history and advance the warm-up count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW; k++) begin
        vhist_r[k] <= '0;
        thist_r[k] <= '0;
      end
      psum_r <= '0;
      seen_r <= '0;
    end else if (in_fire) begin
      for (int k = 0; k < WINDOW - 1; k++) begin
        vhist_r[k] <= vhist_r[k+1];
        thist_r[k] <= thist_r[k+1];
      end
      vhist_r[WINDOW-1] <= in_value;
      thist_r[WINDOW-1] <= in_time;
      psum_r            <= sum_nxt;
      if (!warm) begin
        seen_r <= seen_r + CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (en1)    v1_r <= in_fire && warm;
      if (en2)    v2_r <= v1_r;
      if (en3)    v3_r <= v2_r;
      if (en4)    v4_r <= v3_r;
      if (en5)    v5_r <= v4_r;
      if (en6)    v6_r <= v5_r;
      if (en_out) ov_r <= v6_r;
    end
  end

  // ---------------------------------------------------------------- stage 1: dx, sum pair
  logic signed [DX_W-1:0] dx_r;
  logic signed [S_W-1:0]  s_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dx_r <= dx_nxt;
      s_r  <= s_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2: magnitude product
  logic [TIME_W-1:0] dx_mag;
  logic [S_W-1:0]    s_mag;
  logic [DX_W-1:0]   dx_neg;
  logic [PROD_W-1:0] prod_r;
  logic              neg2_r;

  assign dx_neg = DX_W'(-dx_r);
  assign dx_mag = dx_r[DX_W-1] ? dx_neg[TIME_W-1:0] : dx_r[TIME_W-1:0];
  assign s_mag  = s_r[S_W-1] ? S_W'(-s_r) : S_W'(s_r);

  always_ff @(posedge clk) begin
    if (en2) begin
      prod_r <= PROD_W'(dx_mag) * PROD_W'(s_mag);
      neg2_r <= dx_r[DX_W-1] ^ s_r[S_W-1];
    end
  end

  // ---------------------------------------------------------------- stage 3: estimate high quotient
  logic [2*HW-1:0] hprod;
  logic [HW-1:0]   h3_r, qh_est_r;
  logic [LO-1:0]   l3_r;
  logic            neg3_r;

  assign hprod = {{HW{1'b0}}, prod_r[PROD_W-1:LO]} * {{HW{1'b0}}, RH};

  always_ff @(posedge clk) begin
    if (en3) begin
      qh_est_r <= hprod[2*HW-1:HW];
      h3_r     <= prod_r[PROD_W-1:LO];
      l3_r     <= prod_r[LO-1:0];
      neg3_r   <= neg2_r;
    end
  end

  // ---------------------------------------------------------------- stage 4: correct high quotient
  logic [HW-1:0] rh_full, rh_fix, qh_fix;
  logic [HW-1:0] qh4_r;
  logic [XW-1:0] x4_r;
  logic          neg4_r;

  assign rh_full = h3_r - HW'(qh_est_r * HW'(DIV));

  always_comb begin
    if (rh_full >= HW'(DIV)) begin
      rh_fix = rh_full - HW'(DIV);
      qh_fix = qh_est_r + HW'(1);
    end else begin
      rh_fix = rh_full;
      qh_fix = qh_est_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      qh4_r  <= qh_fix;
      x4_r   <= {rh_fix[RW-1:0], l3_r};
      neg4_r <= neg3_r;
    end
  end

  // ---------------------------------------------------------------- stage 5: estimate low quotient
  logic [2*XW-1:0] xprod;
  logic [XW-1:0]   qx_est_r, x5_r;
  logic [HW-1:0]   qh5_r;
  logic            neg5_r;

  assign xprod = {{XW{1'b0}}, x4_r} * {{XW{1'b0}}, RX};

  always_ff @(posedge clk) begin
    if (en5) begin
      qx_est_r <= xprod[2*XW-1:XW];
      x5_r     <= x4_r;
      qh5_r    <= qh4_r;
      neg5_r   <= neg4_r;
    end
  end

  // ---------------------------------------------------------------- stage 6: correct low quotient
  logic [XW-1:0]     rx_full, qx_fix;
  logic [PROD_W-1:0] q6_r;
  logic              neg6_r;

  assign rx_full = x5_r - XW'(qx_est_r * XW'(DIV));
  assign qx_fix  = (rx_full >= XW'(DIV)) ? qx_est_r + XW'(1) : qx_est_r;

  always_ff @(posedge clk) begin
    if (en6) begin
      q6_r   <= {qh5_r, qx_fix[LO-1:0]};
      neg6_r <= neg5_r;
    end
  end

  // ---------------------------------------------------------------- output: saturating accumulate
  logic signed [ACC_W-1:0] inc_full, acc_r;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_nxt;
  logic [INC_W-1:0]        inc_r;
  logic                    rising_r;

  assign inc_full = neg6_r ? -$signed(ACC_W'(q6_r)) : $signed(ACC_W'(q6_r));
  assign acc_sum  = {acc_r[ACC_W-1], acc_r} + {inc_full[ACC_W-1], inc_full};

  // clip to the signed limits when the top two bits of the sum disagree
  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_nxt = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (en_out && v6_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && v6_r) begin
      inc_r    <= inc_full[INC_W-1:0];
      rising_r <= !neg6_r && (q6_r != '0);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {(OUT_TDATA_W - ACC_W - INC_W - 1)'(0), rising_r, inc_r, acc_r};

  // ---------------------------------------------------------------- assertions
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (!ov_r || out_tready) |-> in_tready)
    else $error("input stalled although the result side is free");

  a_warmup_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !warm) |=> !v1_r)
    else $error("warm-up sample entered the pipeline as a result");

  a_acc_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !(en_out && v6_r) |=> $stable(acc_r))
    else $error("accumulator changed without a new result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= CNT_W'(WINDOW))
    else $error("warm-up count ran past the window length");

endmodule

`default_nettype wire

// ===== tb/smoothed_trapezoid_integrator_test.sv =====
// Self-checking test of the smoothed trapezoid integrator: a table of directed samples,
// random sample streams and a short run of full-scale square waves in time and value.
// Depends on sti_pkg and smoothed_trapezoid_integrator.
`timescale 1ns / 100ps

module smoothed_trapezoid_integrator_test;
  import sti_pkg::*;

  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;
  localparam int     MAX_GAP = 13;

  typedef struct packed {
    logic signed [ACC_W-1:0] integral;
    logic signed [INC_W-1:0] increment;
    logic                    rising;
  } area_result_t;

  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    area_result_t       area;
  } sample_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // sample_time [31:0], sample_value [47:32]
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // running_integral [63:0], area_increment [111:64], rising [112], zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;

  // predicted block state
  logic signed [VALUE_W-1:0] window_values [WINDOW_DEF];
  logic [TIME_W-1:0]         window_times [WINDOW_DEF];
  int                        window_sum;
  int                        fill_count;
  longint                    integral_acc;

  area_result_t expected_areas [$];
  sample_row_t  directed_rows [$];
  int           fault_count;
  bit           source_idle;
  bit           sink_idle;
  int           hold_off_cycles;

  smoothed_trapezoid_integrator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  // Advance the window by one sample; return 1 when the sample yields an area result.
  function automatic bit integrate_sample(input logic [TIME_W-1:0] stamp,
                                          input logic signed [VALUE_W-1:0] value,
                                          output area_result_t area);
    int     next_sum;
    longint span;
    longint increment;
    bit     warming;
    area      = '0;
    // the oldest slot is still zero during warm-up, so one sum update fits both cases
    next_sum  = window_sum - window_values[0] + value;
    span      = longint'(window_times[1]) - longint'(window_times[0]);
    increment = span * longint'(window_sum + next_sum) / (2 * WINDOW_DEF);
    warming   = fill_count < WINDOW_DEF;
    for (int k = 0; k < WINDOW_DEF - 1; k++) begin
      window_values[k] = window_values[k + 1];
      window_times[k]  = window_times[k + 1];
    end
    window_values[WINDOW_DEF - 1] = value;
    window_times[WINDOW_DEF - 1]  = stamp;
    window_sum = next_sum;
    if (warming) begin
      fill_count++;
      return 1'b0;
    end
    // clip the running integral at the 64-bit limits
    if (increment > 0 && integral_acc > ACC_MAX - increment) begin
      integral_acc = ACC_MAX;
    end else if (increment < 0 && integral_acc < ACC_MIN - increment) begin
      integral_acc = ACC_MIN;
    end else begin
      integral_acc = integral_acc + increment;
    end
    area.integral  = integral_acc;
    area.increment = increment[INC_W-1:0];
    area.rising    = increment > 0;
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [TIME_W-1:0] stamp,
                                  input logic [VALUE_W-1:0] value,
                                  input bit typed, input area_result_t area);
    sample_row_t row;
    row.stamp = stamp;
    row.value = value;
    row.typed = typed;
    row.area  = area;
    directed_rows = {directed_rows, row};
  endfunction

  // Offer one sample request after an optional gap; return once it is accepted.
  task automatic offer_sample(input logic [TIME_W-1:0] stamp, input logic [VALUE_W-1:0] value);
    int gap;
    gap = source_idle ? $urandom_range(0, MAX_GAP) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {value, stamp};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic stream_sample(input logic [TIME_W-1:0] stamp, input logic [VALUE_W-1:0] value);
    area_result_t area;
    offer_sample(stamp, value);
    if (integrate_sample(stamp, value, area)) expected_areas = {expected_areas, area};
  endtask

  // Drop the request and hold until every expected area result has arrived.
  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_areas.size() != 0) @(posedge clk);
  endtask

  // One period of a square wave in time and value, aligned so that both the
  // rising and the falling time step see a full window of one sign.
  task automatic pump_period(input bit upward);
    logic [TIME_W-1:0]  stamp;
    logic [VALUE_W-1:0] value;
    for (int p = 0; p < 12; p++) begin
      stamp = (p >= 1 && p <= 6) ? 32'hFFFF_FFFF : 32'h0;
      value = ((p < 6) == upward) ? 16'h7FFF : 16'h8000;
      stream_sample(stamp, value);
    end
  endtask

  task automatic check_area(input logic [OUT_TDATA_W-1:0] data);
    area_result_t want;
    area_result_t got;
    got.integral  = data[ACC_W-1:0];
    got.increment = data[ACC_W+INC_W-1:ACC_W];
    got.rising    = data[ACC_W+INC_W];
    if (expected_areas.size() == 0) begin
      if (fault_count < 10) begin
        $display("unexpected result: integral %0d increment %0d rising %0b",
                 got.integral, got.increment, got.rising);
      end
      fault_count++;
    end else begin
      want = expected_areas.pop_front();
      if (got.integral !== want.integral || got.increment !== want.increment ||
          got.rising !== want.rising) begin
        if (fault_count < 10) begin
          $display("mismatch: integral %0d/%0d increment %0d/%0d rising %0b/%0b (exp/act)",
                   want.integral, got.integral, want.increment, got.increment,
                   want.rising, got.rising);
        end
        fault_count++;
      end
    end
  endtask

  // Result side: stall per result, or for a long hold-off when one is requested.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        check_area(out_tdata);
        stall_left = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (hold_off_cycles != 0) begin
        stall_left      = hold_off_cycles;
        hold_off_cycles = 0;
      end
    end
  end

  initial begin : stimulus
    area_result_t       first_area;
    logic [TIME_W-1:0]  stamp;
    logic [VALUE_W-1:0] value;

    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    source_idle     = 1'b1;
    sink_idle       = 1'b1;
    hold_off_cycles = 0;
    fault_count     = 0;
    window_sum      = 0;
    fill_count      = 0;
    integral_acc    = 0;
    for (int k = 0; k < WINDOW_DEF; k++) begin
      window_values[k] = '0;
      window_times[k]  = '0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // warm-up with full-scale values, then the first result: dx of one tick
    for (int k = 0; k < WINDOW_DEF; k++) add_row(k, 16'h7FFF, 1'b0, '0);
    first_area.integral  = 64'sd32767;
    first_area.increment = 48'sd32767;
    first_area.rising    = 1'b1;
    add_row(32'd5, 16'h7FFF, 1'b1, first_area);
    // time jumps to the top and back to zero, values at the negative limit
    add_row(32'hFFFF_FFFF, 16'h8000, 1'b0, '0);
    add_row(32'hFFFF_FFFF, 16'h8000, 1'b0, '0);
    for (int k = 0; k < 5; k++) add_row(32'h0, 16'h8000, 1'b0, '0);
    // mid-range stamps, zero and unit values, repeated stamps give zero area
    add_row(32'h8000_0000, 16'h0000, 1'b0, '0);
    add_row(32'h8000_0000, 16'h0000, 1'b0, '0);
    add_row(32'h7FFF_FFFF, 16'h0001, 1'b0, '0);
    add_row(32'h7FFF_FFFF, 16'hFFFF, 1'b0, '0);
    add_row(32'd100, 16'hFFFF, 1'b0, '0);
    add_row(32'd100, 16'd12345, 1'b0, '0);
    add_row(32'd200, -16'sd12345, 1'b0, '0);
    add_row(32'd300, 16'h7FFF, 1'b0, '0);
    add_row(32'd300, 16'h7FFF, 1'b0, '0);
    add_row(32'd400, 16'h8000, 1'b0, '0);

    foreach (directed_rows[i]) begin
      offer_sample(directed_rows[i].stamp, directed_rows[i].value);
      if (integrate_sample(directed_rows[i].stamp, directed_rows[i].value, first_area)) begin
        expected_areas = {expected_areas,
                          (directed_rows[i].typed ? directed_rows[i].area : first_area)};
      end
    end
    wait_for_results();

    // random streams: mostly rising stamps, some jumps and repeats
    stamp = 32'h0;
    for (int i = 0; i < 1000; i++) begin
      if (i % 100 == 0) begin
        source_idle = ($urandom_range(0, 3) != 0);
        sink_idle   = ($urandom_range(0, 3) != 0);
      end
      // stall the result side for long while samples keep coming
      if (i == 300) begin
        source_idle     = 1'b0;
        hold_off_cycles = 80;
      end
      if (i == 600) wait_for_results();
      case ($urandom_range(0, 9))
        0:       stamp = $urandom();
        1:       stamp = stamp;
        2:       stamp = stamp - $urandom_range(0, 1000);
        default: stamp = stamp + $urandom_range(0, 1000);
      endcase
      case ($urandom_range(0, 4))
        0:       value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        1:       value = 16'($urandom_range(0, 16) - 8);
        default: value = 16'($urandom());
      endcase
      stream_sample(stamp, value);
    end
    wait_for_results();

    // full-scale time steps against full windows of either sign, back to back
    source_idle = 1'b0;
    sink_idle   = 1'b0;
    repeat (3) pump_period(1'b1);
    repeat (3) pump_period(1'b0);
    wait_for_results();

    repeat (20) @(posedge clk);
    @(negedge clk);
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
